### design/brb_pkg.sv
// Shared constants and types for the byte ring buffer with read window.
package brb_pkg;

  localparam int unsigned DEPTH_DEF = 256;

  localparam int unsigned REQ_W    = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned COUNT_W  = 9;
  localparam int unsigned STATUS_W = 3;

  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 48;

  localparam logic [REQ_W-1:0] REQ_PUT    = 3'd0;
  localparam logic [REQ_W-1:0] REQ_GET    = 3'd1;
  localparam logic [REQ_W-1:0] REQ_OPEN   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_COMMIT = 3'd3;
  localparam logic [REQ_W-1:0] REQ_FLUSH  = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 3'd0,
    ST_BUSY   = 3'd1,
    ST_FULL   = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_TOOBIG = 3'd4
  } status_t;

endpackage

### design/byte_ring_buffer_with_read_window_top.sv
// Byte ring buffer with zero-copy read window: request stage, state update, result stage.
//
//  channel  direction  tdata (low bit up)                               tuser     tlast
//  in_      slave      data_in[7:0], commit_count[16:8]                 req_type  burst_last
//  out_     master     data_out[7:0], window_start[15:8],               status    last_out
//                      window_len[24:16], free_count[33:25], used_count[42:34]
//
//  One transaction per cycle while out_tready is held high; a transaction passes
//  through the input register, then the result register. A stalled result holds
//  while one more transaction waits in the input register. Reset clears indices,
//  full flag, window and valid bits; storage is not cleared.
module byte_ring_buffer_with_read_window_top #(
  parameter int unsigned DEPTH = brb_pkg::DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [brb_pkg::IN_DATA_W-1:0]    in_tdata,   // data_in, commit_count
  input  logic [brb_pkg::REQ_W-1:0]        in_tuser,   // req_type
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [brb_pkg::OUT_DATA_W-1:0]   out_tdata,  // data_out, window_start,
                                                       // window_len, free_count, used_count
  output logic [brb_pkg::STATUS_W-1:0]     out_tuser,  // status
  output logic                             out_tlast
);
  import brb_pkg::*;

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CW    = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int unsigned IW    = (IDX_W > BYTE_W) ? IDX_W : BYTE_W;

  function automatic logic [IDX_W-1:0] adv1(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(DEPTH - 1)) begin
      res = '0;
    end else begin
      res = idx + IDX_W'(1);
    end
    return res;
  endfunction

  function automatic logic [CW-1:0] filled(input logic [IDX_W-1:0] wr,
                                           input logic [IDX_W-1:0] rd,
                                           input logic             full);
    logic [CW-1:0] res;
    if (wr == rd) begin
      res = full ? CW'(DEPTH) : '0;
    end else if (wr > rd) begin
      res = CW'(wr) - CW'(rd);
    end else begin
      res = CW'(wr) + CW'(DEPTH) - CW'(rd);
    end
    return res;
  endfunction

  logic [BYTE_W-1:0] mem [DEPTH];

  logic [IDX_W-1:0]   wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               full_r, full_nxt;
  logic [CNT_W-1:0]   win_len_r, win_len_nxt;

  logic               s1_valid_r;
  logic [REQ_W-1:0]   s1_req_r;
  logic [BYTE_W-1:0]  s1_din_r;
  logic [COUNT_W-1:0] s1_cnt_r;
  logic               s1_last_r;

  logic               s2_valid_r;
  status_t            status_r, status_nxt;
  logic [BYTE_W-1:0]  wstart_r, wstart_nxt;
  logic [COUNT_W-1:0] wlen_r, wlen_nxt;
  logic [COUNT_W-1:0] free_r, free_nxt;
  logic [COUNT_W-1:0] used_r, used_nxt;
  logic               last_r;
  logic               get_ok_r, get_ok_nxt;
  logic [BYTE_W-1:0]  rd_data_r;

  logic               s2_load;
  logic               step;
  logic               wr_en;
  logic [CW-1:0]      used_cur;
  logic [CW-1:0]      used_after;
  logic [CW-1:0]      free_after;
  logic [CW-1:0]      to_end;
  logic [CW-1:0]      win_cand;
  logic [CW-1:0]      cnt_ext;
  logic [CW-1:0]      win_ext;
  logic [CW-1:0]      commit_sum;
  logic [IW-1:0]      rd_ext;
  logic [IDX_W-1:0]   rd_step;

  assign s2_load   = s1_valid_r && (!s2_valid_r || out_tready);
  assign step      = s2_load;
  assign in_tready = !s1_valid_r || s2_load;

  always_comb begin
    wr_idx_nxt  = wr_idx_r;
    rd_idx_nxt  = rd_idx_r;
    full_nxt    = full_r;
    win_len_nxt = win_len_r;
    status_nxt  = ST_OK;
    wstart_nxt  = '0;
    wlen_nxt    = '0;
    get_ok_nxt  = 1'b0;
    wr_en       = 1'b0;
    used_cur    = filled(wr_idx_r, rd_idx_r, full_r);
    to_end      = CW'(DEPTH) - CW'(rd_idx_r);
    win_cand    = (used_cur < to_end) ? used_cur : to_end;
    cnt_ext     = CW'(s1_cnt_r);
    win_ext     = CW'(win_len_r);
    commit_sum  = CW'(rd_idx_r) + cnt_ext;
    rd_ext      = IW'(rd_idx_r);
    rd_step     = adv1(rd_idx_r);
    case (s1_req_r)
      REQ_PUT: begin
        if (used_cur == CW'(DEPTH)) begin
          status_nxt = ST_FULL;
        end else begin
          wr_en      = 1'b1;
          wr_idx_nxt = adv1(wr_idx_r);
          if (adv1(wr_idx_r) == rd_idx_r) begin
            full_nxt = 1'b1;
          end
        end
      end
      REQ_GET: begin
        if (win_len_r != '0) begin
          status_nxt = ST_BUSY;
        end else if (used_cur == '0) begin
          status_nxt = ST_EMPTY;
        end else begin
          get_ok_nxt = 1'b1;
          rd_idx_nxt = rd_step;
          if (wr_idx_r == rd_step) begin
            full_nxt = 1'b0;
          end
        end
      end
      REQ_OPEN: begin
        if (win_len_r != '0) begin
          status_nxt = ST_BUSY;
        end else begin
          win_len_nxt = win_cand[CNT_W-1:0];
          wstart_nxt  = rd_ext[BYTE_W-1:0];
          wlen_nxt    = win_cand[COUNT_W-1:0];
        end
      end
      REQ_COMMIT: begin
        if (cnt_ext > win_ext) begin
          status_nxt = ST_TOOBIG;
        end else begin
          win_len_nxt = '0;
          if (s1_cnt_r != '0) begin
            rd_idx_nxt = (commit_sum == CW'(DEPTH)) ? '0 : commit_sum[IDX_W-1:0];
            if (wr_idx_r == rd_idx_nxt) begin
              full_nxt = 1'b0;
            end
          end
        end
      end
      REQ_FLUSH: begin
        wr_idx_nxt  = '0;
        rd_idx_nxt  = '0;
        full_nxt    = 1'b0;
        win_len_nxt = '0;
      end
      default: begin
      end
    endcase
    used_after = filled(wr_idx_nxt, rd_idx_nxt, full_nxt);
    free_after = CW'(DEPTH) - used_after;
    used_nxt   = used_after[COUNT_W-1:0];
    free_nxt   = free_after[COUNT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r   <= '0;
      rd_idx_r   <= '0;
      full_r     <= 1'b0;
      win_len_r  <= '0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        s1_valid_r <= 1'b1;
      end else if (s2_load) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_load) begin
        s2_valid_r <= 1'b1;
      end else if (out_tready) begin
        s2_valid_r <= 1'b0;
      end
      if (step) begin
        wr_idx_r  <= wr_idx_nxt;
        rd_idx_r  <= rd_idx_nxt;
        full_r    <= full_nxt;
        win_len_r <= win_len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_req_r  <= in_tuser;
      s1_din_r  <= in_tdata[BYTE_W-1:0];
      s1_cnt_r  <= in_tdata[BYTE_W +: COUNT_W];
      s1_last_r <= in_tlast;
    end
    if (step) begin
      status_r <= status_nxt;
      wstart_r <= wstart_nxt;
      wlen_r   <= wlen_nxt;
      free_r   <= free_nxt;
      used_r   <= used_nxt;
      last_r   <= s1_last_r;
      get_ok_r <= get_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && wr_en) begin
      mem[wr_idx_r] <= s1_din_r;
    end
    if (step && get_ok_nxt) begin
      rd_data_r <= mem[rd_idx_r];
    end
  end

  assign out_tvalid = s2_valid_r;
  assign out_tuser  = status_r;
  assign out_tlast  = last_r;
  assign out_tdata  = {5'b0, used_r, free_r, wlen_r, wstart_r,
                       (get_ok_r ? rd_data_r : {BYTE_W{1'b0}})};

endmodule
